// ===== hdl/mmms_pkg.sv =====
// shared constants and types for the median, mean and mode statistics block
package mmms_pkg;
  localparam int MaxSamples  = 64;
  localparam int SampleWidth = 16;
  localparam int AddrWidth   = $clog2(MaxSamples);
  localparam int CountWidth  = $clog2(MaxSamples + 1);
  localparam int SumWidth    = SampleWidth + AddrWidth;

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic [AddrWidth-1:0] addr_t;
  typedef logic [CountWidth-1:0] count_t;

  typedef struct packed {
    logic signed [SampleWidth:0] median_doubled;
    sample_t                     mean;
    sample_t                     mode_first;
    sample_t                     mode_second;
    logic                        bimodal;
    count_t                      mode_count;
    logic [SampleWidth-1:0]      spread;
    count_t                      sample_count;
    logic                        overflow;
  } result_t;
endpackage

// ===== hdl/median_mean_mode_stats_top.sv =====
// top level of the median, mean, spread and mode statistics block
//
//  channel  dir  fields (tdata low bit up)                          tuser/tlast
//  s_axis   in   sample[15:0]                                        tlast=last
//  m_axis   out  median_doubled, mean, mode_first, mode_second,      -
//                bimodal, mode_count, spread, sample_count, overflow
//
// samples load one per cycle into the sample memory while the input is not stalled
// after the last transfer the memory is insertion sorted in place, then scanned once;
// the mean divider runs alongside
// rst clears counters and extremes; the memory itself is not cleared
// input stalls from the last transfer until the result is held in the output register
module median_mean_mode_stats_top
  import mmms_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,  // sample
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata   // median_doubled, mean, mode_first, mode_second,
                                      // bimodal, mode_count, spread, sample_count, overflow
);
  logic                       busy;
  logic                       acc;
  logic                       keep;
  count_t                     cnt;
  logic signed [SumWidth-1:0] sum;
  sample_t                    mn;
  sample_t                    mx;
  logic                       dropped;
  sample_t                    s;
  logic                       go;
  count_t                     n_go;
  logic signed [SumWidth-1:0] sum_go;
  logic                       sort_done;
  logic                       div_done;
  logic                       sort_ok;
  logic                       div_ok;
  sample_t                    quotient;
  logic signed [SampleWidth:0] med;
  sample_t                    mf;
  sample_t                    ms;
  logic                       bim;
  count_t                     mc;
  result_t                    res;
  logic                       out_valid;

  assign s             = sample_t'(s_axis_tdata);
  assign s_axis_tready = !busy;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign keep          = acc && (cnt < count_t'(MaxSamples));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      sum       <= '0;
      mn        <= {1'b0, {(SampleWidth-1){1'b1}}};
      mx        <= {1'b1, {(SampleWidth-1){1'b0}}};
      dropped   <= 1'b0;
      go        <= 1'b0;
      sort_ok   <= 1'b0;
      div_ok    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      go <= 1'b0;
      if (keep) begin
        cnt <= cnt + 1'b1;
        sum <= sum + SumWidth'(s);
        if (s < mn) mn <= s;
        if (s > mx) mx <= s;
      end else if (acc) begin
        dropped <= 1'b1;
      end
      if (acc && s_axis_tlast) begin
        busy <= 1'b1;
        go   <= 1'b1;
      end
      if (sort_done) sort_ok <= 1'b1;
      if (div_done) div_ok <= 1'b1;
      if (sort_ok && div_ok && !out_valid) begin
        out_valid            <= 1'b1;
        res.median_doubled   <= med;
        res.mean             <= quotient;
        res.mode_first       <= mf;
        res.mode_second      <= ms;
        res.bimodal          <= bim;
        res.mode_count       <= mc;
        res.spread           <= mx - mn;
        res.sample_count     <= cnt;
        res.overflow         <= dropped;
        sort_ok              <= 1'b0;
        div_ok               <= 1'b0;
        cnt     <= '0;
        sum     <= '0;
        mn      <= {1'b0, {(SampleWidth-1){1'b1}}};
        mx      <= {1'b1, {(SampleWidth-1){1'b0}}};
        dropped <= 1'b0;
        busy    <= 1'b0;
      end
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
    end
  end

  assign n_go   = cnt;
  assign sum_go = sum;

  mmms_sorter u_sorter (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (keep),
    .wr_addr        (addr_t'(cnt)),
    .wr_data        (s),
    .start          (go),
    .n              (n_go),
    .done           (sort_done),
    .median_doubled (med),
    .mode_first     (mf),
    .mode_second    (ms),
    .bimodal        (bim),
    .mode_count     (mc)
  );

  mmms_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (go),
    .dividend (sum_go),
    .divisor  (n_go),
    .done     (div_done),
    .quotient (quotient)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(104 - $bits(result_t)){1'b0}},
                          res.overflow, res.sample_count, res.spread, res.mode_count,
                          res.bimodal, res.mode_second, res.mode_first, res.mean,
                          res.median_doubled};
endmodule

// ===== hdl/mmms_divider.sv =====
// restoring divider for the mean, one quotient bit per cycle
module mmms_divider
  import mmms_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [SumWidth-1:0] dividend,
  input  count_t                     divisor,
  output logic                       done,
  output sample_t                    quotient
);
  localparam int StepWidth = $clog2(SumWidth + 1);

  logic [SumWidth-1:0]  mag;
  logic [SumWidth-1:0]  quo;
  logic [CountWidth:0]  rem;
  logic [CountWidth:0]  trial;
  logic [StepWidth-1:0] step;
  logic                 neg;
  logic                 busy;

  always_comb begin
    trial = {rem[CountWidth-1:0], mag[SumWidth-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        neg  <= dividend[SumWidth-1];
        mag  <= dividend[SumWidth-1] ? SumWidth'(-dividend) : SumWidth'(dividend);
        rem  <= '0;
        quo  <= '0;
        step <= StepWidth'(SumWidth);
      end else if (busy) begin
        mag <= {mag[SumWidth-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          rem <= trial - {1'b0, divisor};
          quo <= {quo[SumWidth-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[SumWidth-2:0], 1'b0};
        end
        step <= step - 1'b1;
        if (step == StepWidth'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? SampleWidth'(-quo) : SampleWidth'(quo);
endmodule

// ===== hdl/mmms_sorter.sv =====
// in-place insertion sort of the sample memory followed by a run scan for median and modes
module mmms_sorter
  import mmms_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  addr_t   wr_addr,
  input  sample_t wr_data,
  input  logic    start,
  input  count_t  n,
  output logic    done,
  output logic signed [SampleWidth:0] median_doubled,
  output sample_t mode_first,
  output sample_t mode_second,
  output logic    bimodal,
  output count_t  mode_count
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOADK = 7'b0000010,
    S_WAITK = 7'b0000100,
    S_CMP   = 7'b0001000,
    S_WAITJ = 7'b0010000,
    S_SCAN  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  sample_t mem [MaxSamples];
  sample_t rd_data;
  addr_t   rd_addr;
  logic    m_we;
  addr_t   m_waddr;
  sample_t m_wdata;

  state_t  state;
  count_t  i;
  count_t  j;
  sample_t key;
  count_t  lo_idx;
  count_t  hi_idx;
  sample_t prev;
  count_t  run;
  count_t  best;
  sample_t first;
  sample_t second;
  logic    have_prev;

  always_ff @(posedge clk) begin
    if (m_we) mem[m_waddr] <= m_wdata;
    rd_data <= mem[rd_addr];
  end

  // scan index counts up to n; rd_addr set each cycle
  always_comb begin
    m_we    = wr_en;
    m_waddr = wr_addr;
    m_wdata = wr_data;
    rd_addr = addr_t'(j - 1'b1);
    unique case (state)
      S_IDLE:  rd_addr = '0;
      S_LOADK: rd_addr = addr_t'(i);
      S_WAITK: rd_addr = addr_t'(j - 1'b1);
      S_CMP: begin
        if (j != '0 && $signed(rd_data) > key) begin
          m_we    = 1'b1;
          m_waddr = addr_t'(j);
          m_wdata = rd_data;
          rd_addr = addr_t'(j - 2'd2);
        end else begin
          m_we    = 1'b1;
          m_waddr = addr_t'(j);
          m_wdata = key;
          rd_addr = addr_t'(i + 1'b1);
        end
      end
      S_WAITJ: rd_addr = '0;
      S_SCAN:  rd_addr = addr_t'(i + 1'b1);
      S_DONE:  rd_addr = '0;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            i      <= (n == count_t'(1)) ? count_t'(0) : count_t'(1);
            lo_idx <= count_t'((n - 1'b1) >> 1);
            hi_idx <= count_t'(n >> 1);
            state  <= (n == count_t'(1)) ? S_WAITJ : S_LOADK;
          end
        end
        S_LOADK: begin
          j     <= i;
          state <= S_WAITK;
        end
        S_WAITK: begin
          key   <= rd_data;
          state <= S_CMP;
        end
        S_CMP: begin
          if (j != '0 && $signed(rd_data) > key) begin
            j     <= j - 1'b1;
            state <= (j == count_t'(1)) ? S_CMP : S_CMP;
          end else if (i + 1'b1 == n) begin
            i     <= '0;
            state <= S_WAITJ;
          end else begin
            i     <= i + 1'b1;
            j     <= i + 1'b1;
            state <= S_WAITK;
          end
          // data for j-2 arrives next cycle; a j of 1 moves to 0 with no read needed
        end
        S_WAITJ: begin
          have_prev <= 1'b0;
          best      <= '0;
          run       <= '0;
          state     <= S_SCAN;
        end
        S_SCAN: begin
          if (i == count_t'(0) && !have_prev) begin
            have_prev <= 1'b1;
          end
          if (i == n) begin
            if (run > best) begin
              best   <= run;
              first  <= prev;
              second <= prev;
              bimodal <= 1'b0;
            end else if (run == best && prev != first) begin
              second  <= prev;
              bimodal <= 1'b1;
            end
            state <= S_DONE;
          end else begin
            if (i == lo_idx && i == hi_idx)
              median_doubled <= {rd_data, 1'b0};
            else if (i == lo_idx) median_doubled <= {rd_data[SampleWidth-1], rd_data};
            else if (i == hi_idx)
              median_doubled <= median_doubled + {rd_data[SampleWidth-1], rd_data};
            if (i != '0 && rd_data == prev) begin
              run <= run + 1'b1;
            end else begin
              if (i != '0) begin
                if (run > best) begin
                  best    <= run;
                  first   <= prev;
                  second  <= prev;
                  bimodal <= 1'b0;
                end else if (run == best && prev != first) begin
                  second  <= prev;
                  bimodal <= 1'b1;
                end
              end
              run <= count_t'(1);
            end
            prev <= rd_data;
            i    <= i + 1'b1;
          end
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign mode_first  = first;
  assign mode_second = second;
  assign mode_count  = best;
endmodule
